/* src/epdr_pkg.sv */
`timescale 1ns / 1ps

package epdr_pkg;

  // Window length and measurement width
  localparam int SAMPLES     = 6;
  localparam int PERIOD_BITS = 24;

  localparam int CAP_W        = 16;
  localparam int DUTY_W       = 16;
  localparam int OUT_PERIOD_W = 24;
  localparam int TARGET_W     = 24;

  localparam int TRK_W = PERIOD_BITS + 2;
  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W = PERIOD_BITS + CNT_W;
  localparam int THR_W = TARGET_W + CNT_W;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  localparam logic signed [TRK_W-1:0] OVF_STEP = TRK_W'(2 ** CAP_W);
  localparam logic signed [TRK_W-1:0] PMAX     = (TRK_W'(1) << PERIOD_BITS) - TRK_W'(1);

  localparam logic [DUTY_W-1:0]   DUTY_RESET   = DUTY_W'(100);
  localparam logic [DUTY_W-1:0]   DUTY_MAX     = '1;
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(65000);
  localparam logic [THR_W-1:0]    THR_LO_RESET = THR_W'(TARGET_RESET) * THR_W'(SAMPLES);
  localparam logic [THR_W-1:0]    THR_HI_RESET = THR_LO_RESET + THR_W'(SAMPLES - 1);

  typedef struct packed {
    logic              overflow;
    logic              left_valid;
    logic [CAP_W-1:0]  left_capture;
    logic              right_valid;
    logic [CAP_W-1:0]  right_capture;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic [OUT_PERIOD_W-1:0] left_period;
    logic [OUT_PERIOD_W-1:0] right_period;
    logic                    left_adjusted;
    logic                    right_adjusted;
  } out_beat_t;

  // Per-lane command for one accepted beat
  typedef struct packed {
    logic             fire;
    logic             overflow;
    logic             cap_valid;
    logic [CAP_W-1:0] stamp;
  } lane_cmd_t;

  // Window compare thresholds: sum > hi means average above target,
  // sum < lo means average below target
  typedef struct packed {
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
  } thr_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic [OUT_PERIOD_W-1:0] period;
    logic                    adjusted;
  } lane_res_t;

endpackage

/* src/epdr_in_if.sv */
`timescale 1ns / 1ps

interface epdr_in_if;
  import epdr_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/epdr_out_if.sv */
`timescale 1ns / 1ps

interface epdr_out_if;
  import epdr_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/epdr_lane.sv */
`timescale 1ns / 1ps

module epdr_lane (
  input  logic                clk,
  input  logic                rst,
  input  epdr_pkg::lane_cmd_t cmd,
  input  epdr_pkg::thr_t      thr,
  output epdr_pkg::lane_res_t res
);
  import epdr_pkg::*;

  logic signed [TRK_W-1:0]  tracker, tracker_next;
  logic [SUM_W-1:0]         sum, sum_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  logic [DUTY_W-1:0]        duty, duty_next;
  logic [PERIOD_BITS-1:0]   last_period, last_period_next;

  logic signed [TRK_W-1:0]  trk_inc, trk_ovf, stamp_s, p_raw;
  logic [PERIOD_BITS-1:0]   p_sat;
  logic [SUM_W-1:0]         sum_acc;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     win_done, go_up, go_down;

  always_comb begin
    // apply overflow first, saturating the tracker
    trk_inc = tracker + OVF_STEP;
    if (cmd.overflow) begin
      trk_ovf = (trk_inc > PMAX) ? PMAX : trk_inc;
    end else begin
      trk_ovf = tracker;
    end

    stamp_s = $signed({{(TRK_W - CAP_W){1'b0}}, cmd.stamp});
    p_raw   = trk_ovf + stamp_s;
    if (p_raw < 0) begin
      p_sat = '0;
    end else if (p_raw > PMAX) begin
      p_sat = PMAX[PERIOD_BITS-1:0];
    end else begin
      p_sat = p_raw[PERIOD_BITS-1:0];
    end

    sum_acc  = sum + SUM_W'(p_sat);
    cnt_inc  = cnt + CNT_W'(1);
    win_done = cmd.cap_valid && (cnt_inc == CNT_W'(SAMPLES));
    go_up    = (CMP_W'(sum_acc) > thr.hi) && (duty != DUTY_MAX);
    go_down  = (CMP_W'(sum_acc) < thr.lo) && (duty != '0);

    tracker_next     = trk_ovf;
    sum_next         = sum;
    cnt_next         = cnt;
    duty_next        = duty;
    last_period_next = last_period;
    if (cmd.cap_valid) begin
      tracker_next     = -stamp_s;
      last_period_next = p_sat;
      sum_next         = sum_acc;
      cnt_next         = cnt_inc;
      if (win_done) begin
        sum_next = '0;
        cnt_next = '0;
        if (go_up) begin
          duty_next = duty + DUTY_W'(1);
        end else if (go_down) begin
          duty_next = duty - DUTY_W'(1);
        end
      end
    end

    res.duty     = duty_next;
    res.period   = OUT_PERIOD_W'(last_period_next);
    res.adjusted = win_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracker     <= '0;
      sum         <= '0;
      cnt         <= '0;
      duty        <= DUTY_RESET;
      last_period <= '0;
    end else if (cmd.fire) begin
      tracker     <= tracker_next;
      sum         <= sum_next;
      cnt         <= cnt_next;
      duty        <= duty_next;
      last_period <= last_period_next;
    end
  end

  a_cnt_in_window: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(SAMPLES))
    else $error("sample count left the window");

  a_tracker_cap: assert property (@(posedge clk) disable iff (rst)
    tracker <= PMAX)
    else $error("tracker above saturation limit");

  a_duty_only_at_window: assert property (@(posedge clk) disable iff (rst)
    (!(cmd.fire && win_done)) |=> $stable(duty))
    else $error("duty moved outside a window end");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire && win_done) |=> (sum == '0 && cnt == '0))
    else $error("window end did not clear the sum");
endmodule

/* src/epdr_merge.sv */
`timescale 1ns / 1ps

module epdr_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  epdr_pkg::lane_res_t left_res,
  input  epdr_pkg::lane_res_t right_res,
  output logic                ready,
  epdr_out_if.source          out_ch
);
  import epdr_pkg::*;

  logic      valid;
  out_beat_t beat;

  assign ready        = !valid || out_ch.ready;
  assign out_ch.valid = valid;
  assign out_ch.data  = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  // payload: hold until replaced by the next accepted beat
  always_ff @(posedge clk) begin
    if (fire) begin
      beat.left_duty      <= left_res.duty;
      beat.right_duty     <= right_res.duty;
      beat.left_period    <= left_res.period;
      beat.right_period   <= right_res.period;
      beat.left_adjusted  <= left_res.adjusted;
      beat.right_adjusted <= right_res.adjusted;
    end
  end

  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> valid)
    else $error("accepted beat produced no result");

  a_fire_needs_room: assert property (@(posedge clk) disable iff (rst)
    fire |-> (!valid || out_ch.ready))
    else $error("beat accepted over an untaken result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (valid && out_ch.ready && !fire) |=> !valid)
    else $error("taken result not dropped");
endmodule

/* src/encoder_period_duty_regulator.sv */
`timescale 1ns / 1ps
// Each result beat is registered and reaches out_ch the cycle after its input is accepted.
// Throughput: one beat per cycle unless the sink stalls; each wheel lane finishes
// its update in the accept cycle, and the result register frees as the sink takes its beat.
// Reset (rst, synchronous, active high): trackers, sums, counts and periods
// clear, duties go to 100, target period goes to 65000, output empties.

module encoder_period_duty_regulator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [epdr_pkg::TARGET_W-1:0]   cfg_wr_data,
  epdr_in_if.sink                         in_ch,
  epdr_out_if.source                      out_ch
);
  import epdr_pkg::*;

  // Target period held as window-sum thresholds, so no divide by the
  // window length is needed: avg > target when sum > S*target + S-1,
  // avg < target when sum < S*target.
  logic [THR_W-1:0] thr_lo, thr_lo_next;
  logic [THR_W-1:0] thr_hi, thr_hi_next;

  thr_t      thr;
  lane_cmd_t left_cmd, right_cmd;
  lane_res_t left_res, right_res;
  logic      ready;
  logic      fire;

  always_comb begin
    thr_lo_next = THR_W'(cfg_wr_data) * THR_W'(SAMPLES);
    thr_hi_next = thr_lo_next + THR_W'(SAMPLES - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_lo <= THR_LO_RESET;
      thr_hi <= THR_HI_RESET;
    end else if (cfg_wr_en) begin
      thr_lo <= thr_lo_next;
      thr_hi <= thr_hi_next;
    end
  end

  // accept a beat whenever the result register has room
  assign in_ch.ready = ready;
  assign fire        = in_ch.valid && ready;

  assign thr.lo = CMP_W'(thr_lo);
  assign thr.hi = CMP_W'(thr_hi);

  // fan the beat out to the two wheel lanes; overflow goes to both
  always_comb begin
    left_cmd.fire       = fire;
    left_cmd.overflow   = in_ch.data.overflow;
    left_cmd.cap_valid  = in_ch.data.left_valid;
    left_cmd.stamp      = in_ch.data.left_capture;
    right_cmd.fire      = fire;
    right_cmd.overflow  = in_ch.data.overflow;
    right_cmd.cap_valid = in_ch.data.right_valid;
    right_cmd.stamp     = in_ch.data.right_capture;
  end

  epdr_lane u_left_lane (
    .clk (clk),
    .rst (rst),
    .cmd (left_cmd),
    .thr (thr),
    .res (left_res)
  );

  epdr_lane u_right_lane (
    .clk (clk),
    .rst (rst),
    .cmd (right_cmd),
    .thr (thr),
    .res (right_res)
  );

  // combine both lanes into one result beat and register it
  epdr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .left_res  (left_res),
    .right_res (right_res),
    .ready     (ready),
    .out_ch    (out_ch)
  );

  a_thr_order: assert property (@(posedge clk) disable iff (rst)
    thr_hi == thr_lo + THR_W'(SAMPLES - 1))
    else $error("threshold pair out of step");

  a_cfg_load: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (thr_lo == $past(thr_lo_next)))
    else $error("target write not taken");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    (!out_ch.valid) |-> in_ch.ready)
    else $error("input stalled with empty output");
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import epdr_pkg::*;

  localparam int     LEFT         = 0;
  localparam int     RIGHT        = 1;
  localparam longint WRAP_TICKS   = 65536;
  localparam longint PERIOD_CEIL  = (longint'(1) << PERIOD_BITS) - 1;
  localparam int     CHOKE_CYCLES = 400;
  localparam int     DIR_ROWS     = 20;

  // One row of the opening sequence: the beat to send and, where the answer is
  // plain from the arithmetic, the status typed in by hand.
  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } dir_row_t;

  // Per-wheel copy of the regulator state at the block's own widths
  typedef struct {
    logic signed [TRK_W-1:0]  tracker;
    logic [SUM_W-1:0]         sum;
    logic [CNT_W-1:0]         count;
    logic [DUTY_W-1:0]        duty;
    logic [OUT_PERIOD_W-1:0]  period;
  } wheel_t;

  // Opening sequence, walked in order from reset with the reset target of 65000:
  //  - rows 1..5 : idle beat, timestamp extremes, an overflow alone and a capture
  //                below the previous one with no wrap in between (clamped to 0)
  //  - rows 6..9 : four left periods of 81116, so the left window averages exactly
  //                to the target; the duty holds while the window still completes
  //  - rows 10..12: right window above the target, so the right duty rises
  //  - rows 13..18: left window below the target, so the left duty falls
  //  - rows 19..20: overflows; timestamps without their valid bits, then both wheels capture
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000}, 1'b1,
      '{16'd100, 16'd100, 24'd0, 24'd0, 1'b0, 1'b0}},
    '{'{1'b0, 1'b1, 16'hFFFF, 1'b1, 16'h0000}, 1'b1,
      '{16'd100, 16'd100, 24'd65535, 24'd0, 1'b0, 1'b0}},
    '{'{1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000}, 1'b1,
      '{16'd100, 16'd100, 24'd65535, 24'd0, 1'b0, 1'b0}},
    '{'{1'b0, 1'b1, 16'h0000, 1'b1, 16'hFFFF}, 1'b1,
      '{16'd100, 16'd100, 24'd1, 24'd131071, 1'b0, 1'b0}},
    '{'{1'b0, 1'b0, 16'h0000, 1'b1, 16'h0010}, 1'b1,
      '{16'd100, 16'd100, 24'd1, 24'd0, 1'b0, 1'b0}},
    '{'{1'b1, 1'b1, 16'd15580, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'd31160, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'd46740, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'd62320, 1'b0, 16'h0000}, 1'b1,
      '{16'd100, 16'd100, 24'd81116, 24'd0, 1'b1, 1'b0}},
    '{'{1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h0000, 1'b1, 16'hFFFF}, 1'b1,
      '{16'd100, 16'd101, 24'd81116, 24'd0, 1'b0, 1'b1}},
    '{'{1'b0, 1'b1, 16'h1000, 1'b1, 16'h8000}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h2000, 1'b0, 16'hFFFF}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h3000, 1'b1, 16'h8001}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h0001, 1'b0, 16'h1234}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h0002, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'hFFFF, 1'b1, 16'h0000}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic                cfg_wr_en;
  logic [TARGET_W-1:0] cfg_wr_data;

  epdr_in_if  in_ch();
  epdr_out_if out_ch();

  encoder_period_duty_regulator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Predictor state and the statuses still owed by the block, oldest first
  wheel_t              wheel [2];
  logic [TARGET_W-1:0] target_q;
  out_beat_t           status_due [$];
  out_beat_t           want;

  int mismatches     = 0;
  int beats_sent     = 0;
  int windows_seen   = 0;
  int floor_seen     = 0;
  int saturated_seen = 0;
  bit calm           = 1'b0;
  bit choke_req      = 1'b0;

  int                  n;
  int                  drain;
  logic [TARGET_W-1:0] goal;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Take one timestamp on a wheel: measure and clamp the period, reload the
  // tracker and, once a full window has been summed, nudge the duty towards the
  // target. Returns 1 when the window closed on this beat.
  function automatic bit measure_period(int w, logic [CAP_W-1:0] stamp);
    longint p;
    longint avg;
    p = longint'(wheel[w].tracker) + longint'(stamp);
    if (p < 0) p = 0;
    if (p > PERIOD_CEIL) p = PERIOD_CEIL;
    wheel[w].period  = OUT_PERIOD_W'(p);
    wheel[w].tracker = TRK_W'(-longint'(stamp));
    wheel[w].sum     = wheel[w].sum + SUM_W'(p);
    wheel[w].count   = wheel[w].count + 1'b1;
    if (wheel[w].count < SAMPLES) return 1'b0;
    avg = longint'(wheel[w].sum) / SAMPLES;
    if (avg > longint'(target_q) && wheel[w].duty != '1) wheel[w].duty = wheel[w].duty + 1'b1;
    if (avg < longint'(target_q) && wheel[w].duty != '0) wheel[w].duty = wheel[w].duty - 1'b1;
    wheel[w].sum   = '0;
    wheel[w].count = '0;
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted beat and return the status it owes
  function automatic out_beat_t predict_status(in_beat_t b);
    out_beat_t s;
    longint    t;
    s = '0;
    // Apply the timer wrap before either capture, saturating the trackers
    if (b.overflow) begin
      for (int w = 0; w < 2; w++) begin
        t = longint'(wheel[w].tracker) + WRAP_TICKS;
        wheel[w].tracker = TRK_W'((t > PERIOD_CEIL) ? PERIOD_CEIL : t);
      end
    end
    s.left_adjusted  = b.left_valid  ? measure_period(LEFT,  b.left_capture)  : 1'b0;
    s.right_adjusted = b.right_valid ? measure_period(RIGHT, b.right_capture) : 1'b0;
    s.left_duty      = wheel[LEFT].duty;
    s.right_duty     = wheel[RIGHT].duty;
    s.left_period    = wheel[LEFT].period;
    s.right_period   = wheel[RIGHT].period;
    return s;
  endfunction

  function automatic in_beat_t random_beat(int ovf_pct, int cap_pct);
    in_beat_t b;
    b.overflow      = ($urandom_range(99) < ovf_pct);
    b.left_valid    = ($urandom_range(99) < cap_pct);
    b.left_capture  = 16'($urandom);
    b.right_valid   = ($urandom_range(99) < cap_pct);
    b.right_capture = 16'($urandom);
    return b;
  endfunction

  // Offer one beat, with a random gap ahead of it unless calm, and hold it until
  // the block takes it. The owed status is booked at the accepting edge.
  task automatic offer_beat(input in_beat_t b, input logic typed, input out_beat_t typed_want);
    int        gap;
    out_beat_t calc;
    gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(3, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.data  <= random_beat(50, 50);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    calc = predict_status(b);
    status_due.push_back(typed ? typed_want : calc);
    beats_sent++;
  endtask

  // Drop valid, let the block drain, then load a new target while it is idle
  task automatic set_target(input logic [TARGET_W-1:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    target_q     = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Check every result beat the sink takes against the oldest owed status
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("result beat arrived with no status owed");
        mismatches++;
      end else begin
        want = status_due.pop_front();
        if (out_ch.data.left_duty !== want.left_duty) begin
          $error("left_duty: expected %0d, got %0d", want.left_duty, out_ch.data.left_duty);
          mismatches++;
        end
        if (out_ch.data.right_duty !== want.right_duty) begin
          $error("right_duty: expected %0d, got %0d", want.right_duty, out_ch.data.right_duty);
          mismatches++;
        end
        if (out_ch.data.left_period !== want.left_period) begin
          $error("left_period: expected %0d, got %0d", want.left_period,
                 out_ch.data.left_period);
          mismatches++;
        end
        if (out_ch.data.right_period !== want.right_period) begin
          $error("right_period: expected %0d, got %0d", want.right_period,
                 out_ch.data.right_period);
          mismatches++;
        end
        if (out_ch.data.left_adjusted !== want.left_adjusted) begin
          $error("left_adjusted: expected %0b, got %0b", want.left_adjusted,
                 out_ch.data.left_adjusted);
          mismatches++;
        end
        if (out_ch.data.right_adjusted !== want.right_adjusted) begin
          $error("right_adjusted: expected %0b, got %0b", want.right_adjusted,
                 out_ch.data.right_adjusted);
          mismatches++;
        end
        windows_seen   += want.left_adjusted + want.right_adjusted;
        floor_seen     += (want.left_duty == '0) + (want.right_duty == '0);
        saturated_seen += (want.left_period == '1) + (want.right_period == '1);
      end
    end
  end

  // Sink pacing: random stalls, none while calm, and one long hold-off on request
  // so that the result register stays full and the block stalls its input
  initial begin : sink_pacing
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        out_ch.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 25);
      end
    end
  end

  // Watchdog: end a hung run
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    // Hold every input at a known value from time zero
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    target_q    = TARGET_W'(65000);
    for (int w = 0; w < 2; w++) begin
      wheel[w].tracker = '0;
      wheel[w].sum     = '0;
      wheel[w].count   = '0;
      wheel[w].duty    = DUTY_W'(100);
      wheel[w].period  = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the opening sequence at the reset target
    for (n = 0; n < DIR_ROWS; n++)
      offer_beat(DIRECTED[n].beat, DIRECTED[n].typed, DIRECTED[n].want);

    // Highest target: every window lands below it, so both duties fall until they
    // sit on the floor. Run the first stretch with no idling on either side.
    set_target('1);
    for (n = 0; n < 650; n++) begin
      calm = (n < 150);
      offer_beat(random_beat(50, 95), 1'b0, '0);
    end
    calm = 1'b0;

    // Zero target: duties climb off the floor. Choke the sink meanwhile and keep
    // offering beats so the block fills and back-pressures.
    set_target('0);
    choke_req = 1'b1;
    for (n = 0; n < 200; n++)
      offer_beat(random_beat(40, 70), 1'b0, '0);

    // Stalled wheels: wrap the timer long enough to saturate both trackers, then
    // capture so that the measured periods saturate as well
    set_target(TARGET_W'(65000));
    for (n = 0; n < 262; n++)
      offer_beat(random_beat(100, 0), 1'b0, '0);
    for (n = 0; n < 4; n++)
      offer_beat(random_beat(100, 100), 1'b0, '0);

    // Targets near the typical average, so windows fall on either side
    repeat (3) begin
      goal = TARGET_W'($urandom_range(140000, 20000));
      set_target(goal);
      for (n = 0; n < 110; n++)
        offer_beat(random_beat(50, 60), 1'b0, '0);
    end

    // Drop valid, wait for the owed statuses, then check that none is left
    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain = 0;
    while (status_due.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d statuses never arrived", status_due.size());
      mismatches++;
    end

    $display("Run: %0d beats over six target settings, %0d averaging windows closed,",
             beats_sent, windows_seen);
    $display("     %0d results at the duty floor, %0d with a saturated period.",
             floor_seen, saturated_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/epdr_pkg.sv
src/epdr_in_if.sv
src/epdr_out_if.sv
src/epdr_lane.sv
src/epdr_merge.sv
src/encoder_period_duty_regulator.sv
tb/testbench.sv
